// File: design/pspt_pkg.sv
`timescale 1ns / 1ps

package pspt_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE    = 3'd0,
    PH_SHORT_LEN = 3'd1,
    PH_WIDE_LEN  = 3'd2,
    PH_STR_BODY  = 3'd3,
    PH_INT_BODY  = 3'd4,
    PH_LONG_LEN  = 3'd5,
    PH_LONG_BODY = 3'd6,
    PH_SKIP      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_STR_BYTE = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_BAD_OP   = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_t;

  // opcodes of the supported subset
  localparam logic [7:0] OP_SHORT_STR  = 8'h55;  // 'U'
  localparam logic [7:0] OP_WIDE_STR   = 8'h58;  // 'X'
  localparam logic [7:0] OP_INT1       = 8'h4B;  // 'K'
  localparam logic [7:0] OP_INT2       = 8'h4D;  // 'M'
  localparam logic [7:0] OP_INT4       = 8'h4A;  // 'J'
  localparam logic [7:0] OP_LONG1      = 8'h8A;
  localparam logic [7:0] OP_PROTO      = 8'h80;
  localparam logic [7:0] OP_PUT        = 8'h71;  // 'q'
  localparam logic [7:0] OP_LONG_PUT   = 8'h72;  // 'r'
  localparam logic [7:0] OP_STOP       = 8'h2E;  // '.'
  localparam logic [7:0] OP_APPEND     = 8'h61;  // 'a'
  localparam logic [7:0] OP_SETITEMS   = 8'h75;  // 'u'
  localparam logic [7:0] OP_MARK       = 8'h28;  // '('
  localparam logic [7:0] OP_EMPTY_LIST = 8'h5D;  // ']'
  localparam logic [7:0] OP_EMPTY_DICT = 8'h7D;  // '}'
  localparam logic [7:0] OP_TUPLE1     = 8'h85;
  localparam logic [7:0] OP_TUPLE2     = 8'h86;
  localparam logic [7:0] OP_TUPLE3     = 8'h87;

  // argument byte index saturates here; only the low four bytes matter
  localparam logic [2:0] POS_FULL = 3'd4;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] remaining;
    logic [2:0]  position;
    logic [31:0] acc;
    logic        finished;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } token_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_OPCODE,
    remaining: 32'd0,
    position:  3'd0,
    acc:       32'd0,
    finished:  1'b0
  };

endpackage

// File: design/pspt_step.sv
`timescale 1ns / 1ps

module pspt_step (
  input  pspt_pkg::parse_state_t cur_i,
  input  logic [7:0]             byte_i,
  input  logic                   end_i,
  output pspt_pkg::parse_state_t nxt_o,
  output pspt_pkg::token_t       tok_o
);

  function automatic pspt_pkg::parse_state_t start_args(pspt_pkg::phase_t ph,
                                                        logic [31:0] cnt,
                                                        logic fin);
    pspt_pkg::parse_state_t s;
    s.phase     = ph;
    s.remaining = cnt;
    s.position  = 3'd0;
    s.acc       = 32'd0;
    s.finished  = fin;
    return s;
  endfunction

  logic [31:0]            acc_add;
  logic [31:0]            acc_keep;
  logic [2:0]             pos_sat;
  logic                   body_done;
  pspt_pkg::parse_state_t nxt;
  pspt_pkg::token_t       tok;

  always_comb begin
    acc_add   = cur_i.acc | (32'(byte_i) << {cur_i.position[1:0], 3'b000});
    acc_keep  = (cur_i.position < pspt_pkg::POS_FULL) ? acc_add : cur_i.acc;
    pos_sat   = (cur_i.position < pspt_pkg::POS_FULL) ? cur_i.position + 3'd1
                                                      : cur_i.position;
    body_done = (cur_i.remaining <= 32'd1);

    nxt       = cur_i;
    tok.valid = 1'b0;
    tok.kind  = pspt_pkg::KIND_STR_BYTE;
    tok.value = 32'd0;
    tok.last  = 1'b0;

    if (!cur_i.finished) begin
      case (cur_i.phase)
        pspt_pkg::PH_OPCODE: begin
          case (byte_i)
            pspt_pkg::OP_SHORT_STR: nxt = start_args(pspt_pkg::PH_SHORT_LEN, 32'd1, 1'b0);
            pspt_pkg::OP_WIDE_STR:  nxt = start_args(pspt_pkg::PH_WIDE_LEN, 32'd4, 1'b0);
            pspt_pkg::OP_INT1:      nxt = start_args(pspt_pkg::PH_INT_BODY, 32'd1, 1'b0);
            pspt_pkg::OP_INT2:      nxt = start_args(pspt_pkg::PH_INT_BODY, 32'd2, 1'b0);
            pspt_pkg::OP_INT4:      nxt = start_args(pspt_pkg::PH_INT_BODY, 32'd4, 1'b0);
            pspt_pkg::OP_LONG1:     nxt = start_args(pspt_pkg::PH_LONG_LEN, 32'd1, 1'b0);
            pspt_pkg::OP_PROTO:     nxt = start_args(pspt_pkg::PH_SKIP, 32'd1, 1'b0);
            pspt_pkg::OP_PUT:       nxt = start_args(pspt_pkg::PH_SKIP, 32'd1, 1'b0);
            pspt_pkg::OP_LONG_PUT:  nxt = start_args(pspt_pkg::PH_SKIP, 32'd4, 1'b0);
            pspt_pkg::OP_APPEND, pspt_pkg::OP_SETITEMS, pspt_pkg::OP_MARK,
            pspt_pkg::OP_EMPTY_LIST, pspt_pkg::OP_EMPTY_DICT,
            pspt_pkg::OP_TUPLE1, pspt_pkg::OP_TUPLE2, pspt_pkg::OP_TUPLE3: begin
              nxt = cur_i;
            end
            pspt_pkg::OP_STOP: nxt.finished = 1'b1;
            default: begin
              tok.valid    = 1'b1;
              tok.kind     = pspt_pkg::KIND_BAD_OP;
              nxt.finished = 1'b1;
            end
          endcase
        end
        pspt_pkg::PH_SHORT_LEN: begin
          if (byte_i == 8'd0) begin
            tok.valid = 1'b1;
            tok.kind  = pspt_pkg::KIND_EMPTY;
            tok.last  = 1'b1;
            nxt       = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
          end else begin
            nxt = start_args(pspt_pkg::PH_STR_BODY, 32'(byte_i), 1'b0);
          end
        end
        pspt_pkg::PH_WIDE_LEN: begin
          if (pos_sat == pspt_pkg::POS_FULL) begin
            if (acc_add == 32'd0) begin
              tok.valid = 1'b1;
              tok.kind  = pspt_pkg::KIND_EMPTY;
              tok.last  = 1'b1;
              nxt       = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
            end else begin
              nxt = start_args(pspt_pkg::PH_STR_BODY, acc_add, 1'b0);
            end
          end else begin
            nxt.acc      = acc_add;
            nxt.position = pos_sat;
          end
        end
        pspt_pkg::PH_STR_BODY: begin
          tok.valid = 1'b1;
          tok.kind  = pspt_pkg::KIND_STR_BYTE;
          tok.value = 32'(byte_i);
          tok.last  = body_done;
          if (body_done) nxt = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
          else nxt.remaining = cur_i.remaining - 32'd1;
        end
        pspt_pkg::PH_LONG_LEN: begin
          if (byte_i == 8'd0) begin
            tok.valid = 1'b1;
            tok.kind  = pspt_pkg::KIND_NUMBER;
            nxt       = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
          end else begin
            nxt = start_args(pspt_pkg::PH_LONG_BODY, 32'(byte_i), 1'b0);
          end
        end
        pspt_pkg::PH_INT_BODY, pspt_pkg::PH_LONG_BODY: begin
          if (body_done) begin
            tok.valid = 1'b1;
            tok.kind  = pspt_pkg::KIND_NUMBER;
            tok.value = acc_keep;
            nxt       = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
          end else begin
            nxt.remaining = cur_i.remaining - 32'd1;
            nxt.acc       = acc_keep;
            nxt.position  = pos_sat;
          end
        end
        pspt_pkg::PH_SKIP: begin
          if (body_done) nxt = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
          else nxt.remaining = cur_i.remaining - 32'd1;
        end
        default: nxt = start_args(pspt_pkg::PH_OPCODE, 32'd0, 1'b0);
      endcase
    end

    // end of table: an unfinished item overrides whatever the byte gave
    if (end_i) begin
      if (!nxt.finished && nxt.phase != pspt_pkg::PH_OPCODE) begin
        tok.valid = 1'b1;
        tok.kind  = pspt_pkg::KIND_TRUNC;
        tok.value = 32'd0;
        tok.last  = 1'b0;
      end
      nxt = pspt_pkg::STATE_RESET;
    end
  end

  assign nxt_o = nxt;
  assign tok_o = tok;

endmodule

// File: design/pickle_subset_token_parser_top.sv
`timescale 1ns / 1ps

// Pickle token parser for a reduced protocol-2 opcode set.
// Input channel (in_*): one table byte per request in in_tdata, in_tlast on
// the final byte of a table. Output channel (out_*): one token per request,
// out_tuser the token kind, out_tdata the string byte or number, out_tlast
// on the final byte of a string and on an empty-string marker.
// A byte accepted from in_* sits in the input register until it moves on;
// its token, if any, enters the token register as it moves on, which a
// stalled output can hold off. Throughput is one byte per cycle while no
// such stall holds: the byte decode is one pass of combinational logic
// between the two registers, with the parse state updated in the same cycle.
// Bytes that produce no token move on even while the output is stalled.
// When out_tready stays low with a token held, the next byte that yields a
// token waits in the input register and in_tready drops until the held
// token is taken.
// rst_n (synchronous, active low) empties both registers and returns the
// parser to waiting for an opcode. A byte with in_tlast also returns the
// parser to that state after it is handled.

module pickle_subset_token_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] table_byte
  input  logic        in_tlast,   // table_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] token_value
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // string_last
);

  logic                   in_v_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  pspt_pkg::parse_state_t state_r;
  pspt_pkg::parse_state_t state_nxt;
  pspt_pkg::token_t       tok;
  logic                   out_v_r;
  pspt_pkg::kind_t        out_kind_r;
  logic [31:0]            out_val_r;
  logic                   out_last_r;
  logic                   adv;

  pspt_step u_step (
    .cur_i  (state_r),
    .byte_i (in_byte_r),
    .end_i  (in_last_r),
    .nxt_o  (state_nxt),
    .tok_o  (tok)
  );

  assign adv       = in_v_r && (!tok.valid || !out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      state_r <= pspt_pkg::STATE_RESET;
      out_v_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r    <= 1'b1;
        in_byte_r <= in_tdata;
        in_last_r <= in_tlast;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) state_r <= state_nxt;
      if (adv && tok.valid) begin
        out_v_r    <= 1'b1;
        out_kind_r <= tok.kind;
        out_val_r  <= tok.value;
        out_last_r <= tok.last;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tuser == pspt_pkg::KIND_STR_BYTE || out_tuser == pspt_pkg::KIND_EMPTY)
    else $error("tlast on a token that is not string data");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pspt_pkg::KIND_EMPTY || out_tuser == pspt_pkg::KIND_BAD_OP ||
                   out_tuser == pspt_pkg::KIND_TRUNC) |-> out_tdata == 32'd0)
    else $error("nonzero value on a marker or error token");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> state_r.phase == pspt_pkg::PH_OPCODE && !state_r.finished)
    else $error("parser not back to opcode after end of table");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r)
    else $error("held token dropped while output stalled");
`endif

endmodule
